>>> hdl/sssp_pkg.sv
// Shared types and constants of the single-source shortest path engine.
package sssp_pkg;

   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 4096;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int EDGE_W    = $clog2(MAX_EDGES);
   localparam int LINK_W    = EDGE_W + 1;
   localparam int CNT_W     = NODE_W + 1;
   localparam int WEIGHT_W  = 16;
   localparam int DIST_W    = 32;

   localparam logic [LINK_W-1:0] NO_LINK    = LINK_W'(MAX_EDGES);
   localparam logic [CNT_W-1:0]  NODE_LIMIT = CNT_W'(MAX_NODES);
   localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7fff_ffff;
   localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      OP_CLEAR    = 3'd0,
      OP_ADD_TWO  = 3'd1,
      OP_ADD_ONE  = 3'd2,
      OP_RUN      = 3'd3,
      OP_QUERY    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_CYCLE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_LINK_RD, S_LINK_WR, S_RUN_INIT, S_POP, S_POP_RD,
      S_POP_CHK, S_EDGE, S_EDGE_RD, S_REL, S_PUSH, S_QUERY, S_QUERY_RES, S_DONE
   } state_type;

   typedef struct packed {
      logic                       en;
      logic [EDGE_W-1:0]          addr;
      logic [NODE_W-1:0]          target;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_wr_type;

   typedef struct packed {
      logic              en;
      logic [EDGE_W-1:0] addr;
      logic [LINK_W-1:0] link;
   } next_wr_type;

   typedef struct packed {
      logic [LINK_W-1:0] first;
      logic [LINK_W-1:0] last;
   } link_entry_type;

   typedef struct packed {
      logic           en;
      logic [NODE_W-1:0] addr;
      link_entry_type data;
   } link_wr_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] path_len;
      logic                     queued;
      logic [CNT_W-1:0]         deqs;
   } run_entry_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      run_entry_type     data;
   } run_wr_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
      logic [NODE_W-1:0] node;
   } deque_wr_type;

endpackage

>>> hdl/sssp_edge_store.sv
// Edge store: target, weight and next-edge link of every stored edge.
module sssp_edge_store (
   input  logic                                clock,
   input  sssp_pkg::edge_wr_type               edge_wr,
   input  sssp_pkg::next_wr_type               next_wr,
   input  logic [sssp_pkg::EDGE_W-1:0]         rd_addr,
   output logic [sssp_pkg::NODE_W-1:0]         rd_target,
   output logic signed [sssp_pkg::WEIGHT_W-1:0] rd_weight,
   output logic [sssp_pkg::LINK_W-1:0]         rd_next
);
   import sssp_pkg::*;

   logic [NODE_W-1:0]          target_mem [MAX_EDGES];
   logic signed [WEIGHT_W-1:0] weight_mem [MAX_EDGES];
   logic [LINK_W-1:0]          next_mem   [MAX_EDGES];

   always_ff @(posedge clock) begin
      if (edge_wr.en) begin
         target_mem[edge_wr.addr] <= edge_wr.target;
         weight_mem[edge_wr.addr] <= edge_wr.weight;
      end
      if (next_wr.en) begin
         next_mem[next_wr.addr] <= next_wr.link;
      end
      rd_target <= target_mem[rd_addr];
      rd_weight <= weight_mem[rd_addr];
      rd_next   <= next_mem[rd_addr];
   end
endmodule

>>> hdl/sssp_node_store.sv
// Per-node tables: adjacency list heads and tails, and search state.
module sssp_node_store (
   input  logic                         clock,
   input  sssp_pkg::link_wr_type        link_wr,
   input  logic [sssp_pkg::NODE_W-1:0]  link_rd_addr,
   output sssp_pkg::link_entry_type     link_rd_data,
   input  sssp_pkg::run_wr_type         run_wr,
   input  logic [sssp_pkg::NODE_W-1:0]  run_rd_addr,
   output sssp_pkg::run_entry_type      run_rd_data
);
   import sssp_pkg::*;

   link_entry_type link_mem [MAX_NODES];
   run_entry_type  run_mem  [MAX_NODES];

   always_ff @(posedge clock) begin
      if (link_wr.en) begin
         link_mem[link_wr.addr] <= link_wr.data;
      end
      if (run_wr.en) begin
         run_mem[run_wr.addr] <= run_wr.data;
      end
      link_rd_data <= link_mem[link_rd_addr];
      run_rd_data  <= run_mem[run_rd_addr];
   end
endmodule

>>> hdl/sssp_deque.sv
// Storage of the circular work deque; pointers live in the controller.
module sssp_deque (
   input  logic                         clock,
   input  sssp_pkg::deque_wr_type       wr,
   input  logic [sssp_pkg::NODE_W-1:0]  rd_addr,
   output logic [sssp_pkg::NODE_W-1:0]  rd_node
);
   import sssp_pkg::*;

   logic [NODE_W-1:0] deque_mem [MAX_NODES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         deque_mem[wr.addr] <= wr.node;
      end
      rd_node <= deque_mem[rd_addr];
   end
endmodule

>>> hdl/single_source_shortest_path.sv
// Shortest path engine: edge loading, deque-based relaxation run and distance queries.
// A clear sweeps the adjacency list heads and tails; a run sweeps the search state,
// then dequeues nodes and walks their edges. Every memory access waits for its
// registered read. One item is in work at a time.
// A synchronous reset starts a sweep of the node tables; items wait until it ends.
module single_source_shortest_path (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_opcode,
   input  logic [10:0]                          req_node_a,
   input  logic [10:0]                          req_node_b,
   input  logic signed [15:0]                   req_weight,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic signed [31:0]                   rsp_distance,
   output logic                                 rsp_reached,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [10:0]                          csr_node_count
);
   import sssp_pkg::*;

   // Controller state. Node numbers are held zero-based inside the block.
   state_type                  state_ff, state_in;
   logic [NODE_W-1:0]          sweep_cnt_ff, sweep_cnt_in;
   logic                       sweep_link_ff, sweep_link_in;
   logic                       sweep_run_ff, sweep_run_in;
   logic [LINK_W-1:0]          edge_total_ff, edge_total_in;
   logic [CNT_W-1:0]           node_count_ff, node_count_in;
   logic                       cycle_ff, cycle_in;
   logic [NODE_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic                       second_ff, second_in;
   logic [NODE_W-1:0]          from_ff, from_in;
   logic [NODE_W-1:0]          to_ff, to_in;
   logic signed [WEIGHT_W-1:0] w_ff, w_in;
   logic [NODE_W-1:0]          u_ff, u_in;
   logic signed [DIST_W-1:0]   du_ff, du_in;
   logic [LINK_W-1:0]          e_ff, e_in;
   logic [NODE_W-1:0]          t_ff, t_in;
   logic signed [DIST_W-1:0]   nd_ff, nd_in;
   logic [CNT_W-1:0]           tdeq_ff, tdeq_in;
   status_type                 res_status_ff, res_status_in;
   logic signed [DIST_W-1:0]   res_dist_ff, res_dist_in;
   logic                       res_reached_ff, res_reached_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic signed [DIST_W-1:0]   rsp_distance_ff, rsp_distance_in;
   logic                       rsp_reached_ff, rsp_reached_in;

   // Memory ports.
   edge_wr_type                edge_wr;
   next_wr_type                next_wr;
   logic [EDGE_W-1:0]          edge_rd_addr;
   logic [NODE_W-1:0]          edge_target;
   logic signed [WEIGHT_W-1:0] edge_weight;
   logic [LINK_W-1:0]          edge_next;
   link_wr_type                link_wr;
   logic [NODE_W-1:0]          link_rd_addr;
   link_entry_type             link_rd_data;
   run_wr_type                 run_wr;
   logic [NODE_W-1:0]          run_rd_addr;
   run_entry_type              run_rd_data;
   deque_wr_type               deque_wr;
   logic [NODE_W-1:0]          deque_rd_addr;
   logic [NODE_W-1:0]          deque_rd_node;

   // Decode of the incoming item.
   logic                       req_accept;
   logic                       a_ok, b_ok;
   logic [LINK_W:0]            edge_need_total;
   logic                       sweep_last;
   logic                       rsp_load;
   logic signed [DIST_W:0]     sum_wide;
   logic signed [DIST_W-1:0]   sum_sat;
   logic                       to_back;

   sssp_edge_store u_edge_store (
      .clock     (clock),
      .edge_wr   (edge_wr),
      .next_wr   (next_wr),
      .rd_addr   (edge_rd_addr),
      .rd_target (edge_target),
      .rd_weight (edge_weight),
      .rd_next   (edge_next)
   );

   sssp_node_store u_node_store (
      .clock        (clock),
      .link_wr      (link_wr),
      .link_rd_addr (link_rd_addr),
      .link_rd_data (link_rd_data),
      .run_wr       (run_wr),
      .run_rd_addr  (run_rd_addr),
      .run_rd_data  (run_rd_data)
   );

   sssp_deque u_deque (
      .clock   (clock),
      .wr      (deque_wr),
      .rd_addr (deque_rd_addr),
      .rd_node (deque_rd_node)
   );

   // The block takes a new item only when the controller is idle; a finished result
   // waits in the output register, so the next item can start meanwhile.
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign a_ok = (req_node_a != '0) && (req_node_a <= node_count_ff);
   assign b_ok = (req_node_b != '0) && (req_node_b <= node_count_ff);
   assign edge_need_total = {1'b0, edge_total_ff} +
                            ((req_opcode == OP_ADD_TWO) ? (LINK_W+1)'(2) : (LINK_W+1)'(1));
   assign sweep_last = (sweep_cnt_ff == NODE_W'(MAX_NODES - 1));
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Saturating sum of the current node's distance and the edge weight.
   assign sum_wide = {du_ff[DIST_W-1], du_ff} +
                     {{(DIST_W+1-WEIGHT_W){edge_weight[WEIGHT_W-1]}}, edge_weight};
   always_comb begin
      if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
         sum_sat = sum_wide[DIST_W] ? DIST_MIN : DIST_MAX;
      end else begin
         sum_sat = sum_wide[DIST_W-1:0];
      end
   end

   // A relaxed node goes to the back when its distance is at least the front node's.
   assign to_back = (fill_ff != '0) && (nd_ff >= run_rd_data.path_len);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_SWEEP: begin
            if (sweep_last) begin
               if (sweep_link_ff && sweep_run_ff) begin
                  state_in = S_IDLE;
               end else if (sweep_run_ff) begin
                  state_in = S_RUN_INIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               case (req_opcode)
                  OP_CLEAR: state_in = S_SWEEP;
                  OP_ADD_TWO, OP_ADD_ONE: begin
                     if (!a_ok || !b_ok || (edge_need_total > (LINK_W+1)'(MAX_EDGES))) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_LINK_RD;
                     end
                  end
                  OP_RUN:   state_in = a_ok ? S_SWEEP : S_DONE;
                  OP_QUERY: state_in = (a_ok && !cycle_ff) ? S_QUERY : S_DONE;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_LINK_RD:   state_in = S_LINK_WR;
         S_LINK_WR:   state_in = second_ff ? S_LINK_RD : S_DONE;
         S_RUN_INIT:  state_in = S_POP;
         S_POP:       state_in = (fill_ff == '0) ? S_DONE : S_POP_RD;
         S_POP_RD:    state_in = S_POP_CHK;
         S_POP_CHK:   state_in = (run_rd_data.deqs >= node_count_ff) ? S_DONE : S_EDGE;
         S_EDGE:      state_in = e_ff[EDGE_W] ? S_POP : S_EDGE_RD;
         S_EDGE_RD:   state_in = ({1'b0, edge_target} >= node_count_ff) ? S_EDGE : S_REL;
         S_REL: begin
            if ((run_rd_data.path_len > nd_ff) && !run_rd_data.queued) begin
               state_in = S_PUSH;
            end else begin
               state_in = S_EDGE;
            end
         end
         S_PUSH:      state_in = S_EDGE;
         S_QUERY:     state_in = S_QUERY_RES;
         S_QUERY_RES: state_in = S_DONE;
         S_DONE:      state_in = rsp_load ? S_IDLE : S_DONE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath registers and memory ports.
   always_comb begin
      sweep_cnt_in    = sweep_cnt_ff;
      sweep_link_in   = sweep_link_ff;
      sweep_run_in    = sweep_run_ff;
      edge_total_in   = edge_total_ff;
      node_count_in   = node_count_ff;
      cycle_in        = cycle_ff;
      head_in         = head_ff;
      fill_in         = fill_ff;
      second_in       = second_ff;
      from_in         = from_ff;
      to_in           = to_ff;
      w_in            = w_ff;
      u_in            = u_ff;
      du_in           = du_ff;
      e_in            = e_ff;
      t_in            = t_ff;
      nd_in           = nd_ff;
      tdeq_in         = tdeq_ff;
      res_status_in   = res_status_ff;
      res_dist_in     = res_dist_ff;
      res_reached_in  = res_reached_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_distance_in = rsp_distance_ff;
      rsp_reached_in  = rsp_reached_ff;

      edge_wr       = '0;
      next_wr       = '0;
      link_wr       = '0;
      run_wr        = '0;
      deque_wr      = '0;
      edge_rd_addr  = e_ff[EDGE_W-1:0];
      link_rd_addr  = from_ff;
      run_rd_addr   = t_ff;
      deque_rd_addr = head_ff;

      // The register value is clamped into the supported node range.
      if (csr_valid && csr_ready) begin
         if (csr_node_count == '0) begin
            node_count_in = CNT_W'(1);
         end else if (csr_node_count > NODE_LIMIT) begin
            node_count_in = NODE_LIMIT;
         end else begin
            node_count_in = csr_node_count;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_SWEEP: begin
            link_wr.en   = sweep_link_ff;
            link_wr.addr = sweep_cnt_ff;
            link_wr.data = '{first: NO_LINK, last: NO_LINK};
            run_wr.en    = sweep_run_ff;
            run_wr.addr  = sweep_cnt_ff;
            run_wr.data  = '{path_len: DIST_MAX, queued: 1'b0, deqs: '0};
            sweep_cnt_in = sweep_cnt_ff + NODE_W'(1);
         end
         S_IDLE: begin
            if (req_accept) begin
               from_in        = NODE_W'(req_node_a - 11'd1);
               to_in          = NODE_W'(req_node_b - 11'd1);
               w_in           = req_weight;
               res_status_in  = ST_OK;
               res_dist_in    = '0;
               res_reached_in = 1'b0;
               sweep_cnt_in   = '0;
               case (req_opcode)
                  OP_CLEAR: begin
                     edge_total_in = '0;
                     sweep_link_in = 1'b1;
                     sweep_run_in  = 1'b0;
                  end
                  OP_ADD_TWO, OP_ADD_ONE: begin
                     second_in = (req_opcode == OP_ADD_TWO);
                     if (!a_ok || !b_ok) begin
                        res_status_in = ST_RANGE;
                     end else if (edge_need_total > (LINK_W+1)'(MAX_EDGES)) begin
                        res_status_in = ST_FULL;
                     end
                  end
                  OP_RUN: begin
                     sweep_link_in = 1'b0;
                     sweep_run_in  = 1'b1;
                     if (!a_ok) begin
                        res_status_in = ST_RANGE;
                     end
                  end
                  OP_QUERY: begin
                     if (!a_ok) begin
                        res_status_in = ST_RANGE;
                     end else if (cycle_ff) begin
                        res_status_in = ST_CYCLE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LINK_RD: begin
            // Write the new edge and fetch the tail of the start node's list.
            edge_wr.en     = 1'b1;
            edge_wr.addr   = edge_total_ff[EDGE_W-1:0];
            edge_wr.target = to_ff;
            edge_wr.weight = w_ff;
            next_wr.en     = 1'b1;
            next_wr.addr   = edge_total_ff[EDGE_W-1:0];
            next_wr.link   = NO_LINK;
            link_rd_addr   = from_ff;
         end
         S_LINK_WR: begin
            link_wr.en        = 1'b1;
            link_wr.addr      = from_ff;
            link_wr.data.last = edge_total_ff;
            if (link_rd_data.last[EDGE_W]) begin
               link_wr.data.first = edge_total_ff;
            end else begin
               link_wr.data.first = link_rd_data.first;
               next_wr.en   = 1'b1;
               next_wr.addr = link_rd_data.last[EDGE_W-1:0];
               next_wr.link = edge_total_ff;
            end
            edge_total_in = edge_total_ff + LINK_W'(1);
            if (second_ff) begin
               second_in = 1'b0;
               from_in   = to_ff;
               to_in     = from_ff;
            end
         end
         S_RUN_INIT: begin
            // The source is the only queued node.
            cycle_in      = 1'b0;
            head_in       = '0;
            fill_in       = CNT_W'(1);
            deque_wr.en   = 1'b1;
            deque_wr.addr = '0;
            deque_wr.node = from_ff;
            run_wr.en     = 1'b1;
            run_wr.addr   = from_ff;
            run_wr.data   = '{path_len: '0, queued: 1'b1, deqs: '0};
         end
         S_POP: begin
            deque_rd_addr = head_ff;
         end
         S_POP_RD: begin
            u_in         = deque_rd_node;
            head_in      = head_ff + NODE_W'(1);
            fill_in      = fill_ff - CNT_W'(1);
            run_rd_addr  = deque_rd_node;
            link_rd_addr = deque_rd_node;
         end
         S_POP_CHK: begin
            if (run_rd_data.deqs >= node_count_ff) begin
               // The node has been taken node_count times: a negative cycle.
               cycle_in      = 1'b1;
               res_status_in = ST_CYCLE;
            end else begin
               run_wr.en   = 1'b1;
               run_wr.addr = u_ff;
               run_wr.data = '{path_len: run_rd_data.path_len, queued: 1'b0,
                               deqs: run_rd_data.deqs + CNT_W'(1)};
               du_in = run_rd_data.path_len;
               e_in  = link_rd_data.first;
            end
         end
         S_EDGE: begin
            edge_rd_addr = e_ff[EDGE_W-1:0];
         end
         S_EDGE_RD: begin
            // Edges whose target lies beyond the node count are skipped.
            e_in          = edge_next;
            t_in          = edge_target;
            nd_in         = sum_sat;
            run_rd_addr   = edge_target;
            deque_rd_addr = head_ff;
         end
         S_REL: begin
            tdeq_in     = run_rd_data.deqs;
            run_rd_addr = deque_rd_node;
            if ((run_rd_data.path_len > nd_ff) && run_rd_data.queued) begin
               run_wr.en   = 1'b1;
               run_wr.addr = t_ff;
               run_wr.data = '{path_len: nd_ff, queued: 1'b1, deqs: run_rd_data.deqs};
               if (t_ff == u_ff) begin
                  du_in = nd_ff;
               end
            end
         end
         S_PUSH: begin
            run_wr.en   = 1'b1;
            run_wr.addr = t_ff;
            run_wr.data = '{path_len: nd_ff, queued: 1'b1, deqs: tdeq_ff};
            if (t_ff == u_ff) begin
               du_in = nd_ff;
            end
            if (fill_ff < NODE_LIMIT) begin
               deque_wr.en   = 1'b1;
               deque_wr.node = t_ff;
               fill_in       = fill_ff + CNT_W'(1);
               if (to_back) begin
                  deque_wr.addr = head_ff + fill_ff[NODE_W-1:0];
               end else begin
                  deque_wr.addr = head_ff - NODE_W'(1);
                  head_in       = head_ff - NODE_W'(1);
               end
            end
         end
         S_QUERY: begin
            run_rd_addr = from_ff;
         end
         S_QUERY_RES: begin
            if (run_rd_data.path_len != DIST_MAX) begin
               res_reached_in = 1'b1;
               res_dist_in    = run_rd_data.path_len;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_distance_in = res_dist_ff;
               rsp_reached_in  = res_reached_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_cnt_ff  <= '0;
         sweep_link_ff <= 1'b1;
         sweep_run_ff  <= 1'b1;
         edge_total_ff <= '0;
         node_count_ff <= NODE_LIMIT;
         cycle_ff      <= 1'b0;
         head_ff       <= '0;
         fill_ff       <= '0;
         second_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         sweep_link_ff <= sweep_link_in;
         sweep_run_ff  <= sweep_run_in;
         edge_total_ff <= edge_total_in;
         node_count_ff <= node_count_in;
         cycle_ff      <= cycle_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         second_ff     <= second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff         <= from_in;
      to_ff           <= to_in;
      w_ff            <= w_in;
      u_ff            <= u_in;
      du_ff           <= du_in;
      e_ff            <= e_in;
      t_ff            <= t_in;
      nd_ff           <= nd_in;
      tdeq_ff         <= tdeq_in;
      res_status_ff   <= res_status_in;
      res_dist_ff     <= res_dist_in;
      res_reached_ff  <= res_reached_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_reached_ff  <= rsp_reached_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_reached  = rsp_reached_ff;

endmodule

>>> sim/sssp_checker.sv
// Checker for the shortest path engine: predicts every result item and compares it.
module sssp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic [10:0]        req_node_a,
   input  logic [10:0]        req_node_b,
   input  logic signed [15:0] req_weight,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_distance,
   input  logic               rsp_reached,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [10:0]        csr_node_count,
   output int                 error_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sssp_pkg::*;

   typedef struct {
      status_type         status;
      logic signed [31:0] distance;
      logic               reached;
   } answer_type;

   answer_type answers_due[$];

   int    edge_to[MAX_EDGES];
   int    edge_cost[MAX_EDGES];
   int    edge_link[MAX_EDGES];
   int    first_edge[MAX_NODES];
   int    last_edge[MAX_NODES];
   int    edges_stored;
   int    best_dist[MAX_NODES];
   bit    in_deque[MAX_NODES];
   int    pop_count[MAX_NODES];
   int    ring[MAX_NODES];
   int    ring_head;
   int    ring_fill;
   int    nodes_in_use;
   bit    cycle_seen;

   function automatic void empty_graph();
      for (int i = 0; i < MAX_NODES; i++) begin
         first_edge[i] = MAX_EDGES;
         last_edge[i]  = MAX_EDGES;
      end
      edges_stored = 0;
   endfunction

   function automatic void append_edge(int from, int to, int cost);
      int idx;
      idx = edges_stored;
      edge_to[idx]   = to;
      edge_cost[idx] = cost;
      edge_link[idx] = MAX_EDGES;
      if (last_edge[from] >= MAX_EDGES) first_edge[from] = idx;
      else edge_link[last_edge[from]] = idx;
      last_edge[from] = idx;
      edges_stored = idx + 1;
   endfunction

   function automatic void enqueue(int n, bit at_back);
      if (ring_fill >= MAX_NODES) return;
      if (at_back) begin
         ring[(ring_head + ring_fill) % MAX_NODES] = n;
      end else begin
         ring_head = (ring_head + MAX_NODES - 1) % MAX_NODES;
         ring[ring_head] = n;
      end
      ring_fill++;
   endfunction

   // Deque-based relaxation with the small-label-first placement rule.
   function automatic void search_from(int src);
      int     u;
      int     e;
      int     t;
      int     nd;
      longint sum;
      for (int i = 0; i < MAX_NODES; i++) begin
         best_dist[i] = 32'h7fff_ffff;
         in_deque[i]  = 0;
         pop_count[i] = 0;
      end
      ring_head  = 0;
      ring_fill  = 0;
      cycle_seen = 0;
      best_dist[src] = 0;
      in_deque[src]  = 1;
      enqueue(src, 1);
      while (ring_fill > 0) begin
         u = ring[ring_head];
         ring_head = (ring_head + 1) % MAX_NODES;
         ring_fill--;
         in_deque[u] = 0;
         if (pop_count[u] >= nodes_in_use) begin
            cycle_seen = 1;
            return;
         end
         pop_count[u]++;
         for (e = first_edge[u]; e < MAX_EDGES; e = edge_link[e]) begin
            t = edge_to[e];
            if (t >= nodes_in_use) continue;
            sum = longint'(best_dist[u]) + longint'(edge_cost[e]);
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            nd = int'(sum);
            if (best_dist[t] > nd) begin
               best_dist[t] = nd;
               if (!in_deque[t]) begin
                  enqueue(t, ring_fill > 0 && nd >= best_dist[ring[ring_head]]);
                  in_deque[t] = 1;
               end
            end
         end
      end
   endfunction

   function automatic answer_type predict_answer(logic [2:0] op, int a, int b, int w);
      answer_type ans;
      bit         a_ok;
      bit         b_ok;
      int         need;
      ans.status   = ST_OK;
      ans.distance = '0;
      ans.reached  = 1'b0;
      a_ok = a >= 1 && a <= nodes_in_use;
      b_ok = b >= 1 && b <= nodes_in_use;
      case (op)
         OP_CLEAR: begin
            empty_graph();
         end
         OP_ADD_TWO, OP_ADD_ONE: begin
            need = (op == OP_ADD_TWO) ? 2 : 1;
            if (!a_ok || !b_ok) ans.status = ST_RANGE;
            else if (edges_stored + need > MAX_EDGES) ans.status = ST_FULL;
            else begin
               append_edge(a - 1, b - 1, w);
               if (op == OP_ADD_TWO) append_edge(b - 1, a - 1, w);
            end
         end
         OP_RUN: begin
            if (!a_ok) ans.status = ST_RANGE;
            else begin
               search_from(a - 1);
               if (cycle_seen) ans.status = ST_CYCLE;
            end
         end
         OP_QUERY: begin
            if (!a_ok) ans.status = ST_RANGE;
            else if (cycle_seen) ans.status = ST_CYCLE;
            else if (best_dist[a - 1] != 32'h7fff_ffff) begin
               ans.reached  = 1'b1;
               ans.distance = best_dist[a - 1];
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         empty_graph();
         for (int i = 0; i < MAX_NODES; i++) begin
            best_dist[i] = 32'h7fff_ffff;
            in_deque[i]  = 0;
            pop_count[i] = 0;
         end
         ring_head    = 0;
         ring_fill    = 0;
         cycle_seen   = 0;
         nodes_in_use = MAX_NODES;
         answers_due.delete();
         error_count  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            nodes_in_use = csr_node_count;
            if (nodes_in_use < 1) nodes_in_use = 1;
            if (nodes_in_use > MAX_NODES) nodes_in_use = MAX_NODES;
         end
         if (req_valid && !req_stall)
            answers_due.insert(answers_due.size(),
                               predict_answer(req_opcode, req_node_a, req_node_b,
                                              req_weight));
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               if (error_count < 10)
                  $display("ERROR: result item with nothing expected (status %0d)",
                           rsp_status);
               error_count++;
            end else begin
               want = answers_due[0];
               answers_due.delete(0);
               if (rsp_status !== want.status || rsp_distance !== want.distance ||
                   rsp_reached !== want.reached) begin
                  if (error_count < 10)
                     $display("ERROR: expected status %0d dist %0d reached %0b, got %0d %0d %0b",
                              want.status, want.distance, want.reached,
                              rsp_status, rsp_distance, rsp_reached);
                  error_count++;
               end
            end
         end
      end
      pending_count = answers_due.size();
   end

endmodule

>>> sim/single_source_shortest_path_test.sv
// Top of the shortest path engine testbench: clock, reset, stimulus and verdict.
module single_source_shortest_path_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sssp_pkg::*;

   // A run that ends in a negative cycle over the full node range is the slowest item.
   localparam int WATCHDOG_LIMIT = 4000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_opcode = '0;
   logic [10:0]        req_node_a = '0;
   logic [10:0]        req_node_b = '0;
   logic signed [15:0] req_weight = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_distance;
   logic               rsp_reached;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [10:0]        csr_node_count = '0;

   int error_count;
   int pending_count;
   int send_gap_pct  = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int runs_sent     = 0;
   int counts_set    = 0;
   int idle_cycles   = 0;
   int active_nodes  = MAX_NODES;

   always #5 clock = ~clock;

   single_source_shortest_path i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_node_a, .req_node_b,
      .req_weight, .rsp_valid, .rsp_stall, .rsp_status, .rsp_distance, .rsp_reached,
      .csr_valid, .csr_ready, .csr_node_count
   );

   sssp_checker i_checker (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_node_a, .req_node_b,
      .req_weight, .rsp_valid, .rsp_stall, .rsp_status, .rsp_distance, .rsp_reached,
      .csr_valid, .csr_ready, .csr_node_count, .error_count, .pending_count
   );

   // The receiver stalls on its own schedule, set by the current idling phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // The watchdog only counts cycles in which no handshake completes.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offers one item, after an optional gap, and holds it until the block takes it.
   task automatic send_item(op_type op, int a, int b, int w);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_node_a <= 11'(a);
      req_node_b <= 11'(b);
      req_weight <= 16'(w);
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (op == OP_RUN) runs_sent++;
   endtask

   // The node count register is only written once every result is back.
   task automatic set_node_count(int value);
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_node_count <= 11'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_nodes = (value < 1) ? 1 : (value > MAX_NODES) ? MAX_NODES : value;
      counts_set++;
   endtask

   // Mostly a node in range, sometimes any 11-bit value.
   function automatic int pick_node();
      if ($urandom_range(9) == 0) return $urandom_range(2047);
      return $urandom_range(1, active_nodes);
   endfunction

   function automatic int pick_weight(bit allow_negative);
      int r;
      r = $urandom_range(99);
      if (r < 65) return $urandom_range(0, 50);
      if (r < 75) return $urandom_range(0, 32767);
      if (r < 80) return 32767;
      if (!allow_negative) return $urandom_range(0, 9);
      if (r < 90) return -$urandom_range(1, 5);
      if (r < 95) return -32768;
      return $signed(16'($urandom()));
   endfunction

   initial begin
      int n;
      int count_value;
      bit negatives;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part on a four-node graph.
      set_node_count(4);
      send_item(OP_ADD_TWO, 1, 2, 0);
      send_item(OP_ADD_ONE, 2, 3, 32767);
      send_item(OP_ADD_ONE, 3, 4, -32768);
      send_item(OP_ADD_ONE, 0, 2, 1);
      send_item(OP_ADD_ONE, 1, 5, 1);
      send_item(OP_ADD_TWO, 2047, 1, 1);
      send_item(op_type'(3'd5), 1, 1, 1);
      send_item(op_type'(3'd7), 2047, 2047, -1);
      send_item(OP_RUN, 0, 0, 0);
      send_item(OP_RUN, 1, 0, 0);
      for (int i = 0; i <= 5; i++) send_item(OP_QUERY, i, 0, 0);
      // A negative two-way edge is a cycle of its own.
      send_item(OP_ADD_TWO, 1, 4, -1);
      send_item(OP_RUN, 1, 0, 0);
      send_item(OP_QUERY, 2, 0, 0);
      // Clearing keeps the last run readable, so the cycle status persists.
      send_item(OP_CLEAR, 0, 0, 0);
      send_item(OP_QUERY, 3, 0, 0);
      send_item(OP_RUN, 2, 0, 0);
      send_item(OP_QUERY, 1, 0, 0);
      send_item(OP_QUERY, 2, 0, 0);

      // Fill the edge store to the brim, then overflow it both ways.
      // The idling phases rotate while the store fills.
      for (int i = 0; i < MAX_EDGES / 2 - 1; i++) begin
         case ((i / 256) % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 59; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 59; end
            default: begin send_gap_pct = 8; stall_pct = 8; end
         endcase
         send_item(OP_ADD_TWO, $urandom_range(1, 4), $urandom_range(1, 4),
                   $urandom_range(1, 100));
      end
      send_item(OP_ADD_ONE, 1, 2, 7);
      send_item(OP_ADD_TWO, 3, 4, 7);
      send_item(OP_ADD_ONE, 4, 1, 7);
      send_item(OP_ADD_ONE, 2, 3, 7);
      send_item(OP_ADD_TWO, 1, 3, 7);
      send_item(OP_RUN, 1, 0, 0);
      for (int i = 1; i <= 4; i++) send_item(OP_QUERY, i, 0, 0);
      send_item(OP_CLEAR, 0, 0, 0);

      // Random rounds: set a size, build a graph, run it and read it back.
      for (int round_no = 0; items_sent < 2200; round_no++) begin
         case (round_no % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 59; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 59; end
            default: begin send_gap_pct = 8; stall_pct = 8; end
         endcase
         n = $urandom_range(99);
         if (n < 70) count_value = $urandom_range(2, 24);
         else if (n < 80) count_value = 1;
         else if (n < 88) count_value = MAX_NODES;
         else if (n < 93) count_value = 0;
         else count_value = $urandom_range(2047);
         set_node_count(count_value);
         send_item(OP_CLEAR, 0, 0, 0);
         negatives = $urandom_range(1);
         repeat ($urandom_range(3, 30)) begin
            if ($urandom_range(2) == 0)
               send_item(OP_ADD_TWO, pick_node(), pick_node(), pick_weight(0));
            else
               send_item(OP_ADD_ONE, pick_node(), pick_node(), pick_weight(negatives));
            if ($urandom_range(19) == 0)
               send_item(op_type'($urandom_range(7)), $urandom_range(2047),
                         $urandom_range(2047), $signed(16'($urandom())));
         end
         // Shrinking the node count leaves edges that point past the new range.
         if ($urandom_range(4) == 0) set_node_count($urandom_range(1, active_nodes));
         repeat ($urandom_range(1, 2)) begin
            send_item(OP_RUN, pick_node(), 0, 0);
            repeat ($urandom_range(5, 15)) send_item(OP_QUERY, pick_node(), 0, 0);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d items with %0d searches over %0d node count settings,",
               items_sent, runs_sent, counts_set);
      $display("including a full edge store, negative cycles and out-of-range nodes.");
      if (error_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
